FILE: sv/ledbms_pkg.sv
package ledbms_pkg;

  // Default build parameters.
  localparam int SINE_TABLE_SIZE_DEF = 1024;
  localparam int FADE_STEP_DEF = 50;

  // Duty range limits.
  localparam logic [11:0] DUTY_MAX = 12'd4095;
  localparam logic [11:0] DUTY_MID = 12'd2047;

  // Scale of the rational sine numerator (16 * 2047).
  localparam int MAG_K_W = 15;
  localparam logic [MAG_K_W-1:0] MAG_K = 15'd32752;

  // Quotient width of the shared divider. The phase stays below the
  // table size and the sine magnitude stays below 2048.
  localparam int DIV_QW = 12;

  // Operating modes, also the encoding of mode_select and mode_after.
  typedef enum logic [2:0] {
    MODE_OFF      = 3'd0,
    MODE_ON       = 3'd1,
    MODE_FADE_IN  = 3'd2,
    MODE_FADE_OUT = 3'd3,
    MODE_SINE     = 3'd4
  } mode_t;

  // Register word indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_MODE_SELECT   = 2'd0,
    REG_ON_DUTY       = 2'd1,
    REG_FADE_INTERVAL = 2'd2,
    REG_SINE_PERIOD   = 2'd3
  } reg_idx_t;

  // Sequencer states of the update engine.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PHASE_GO,
    ST_PHASE_WAIT,
    ST_WMUL,
    ST_MAG_GO,
    ST_MAG_WAIT,
    ST_EMIT
  } fsm_state_t;

  // One record of persistent sequencer state held in the state memory.
  typedef struct packed {
    logic [11:0] duty_level;
    logic [31:0] last_tick;
    logic [15:0] sine_step;
  } state_rec_t;

  // Configuration values and the mode load strobe.
  typedef struct packed {
    logic        mode_wr;
    logic [2:0]  mode_val;
    logic [11:0] on_duty;
    logic [31:0] fade_interval;
    logic [15:0] sine_period;
  } cfg_bus_t;

endpackage

FILE: sv/led_brightness_mode_sequencer_core.sv
// Channel   Direction  Ports                                   Transaction
// in        input      in_valid, in_stall, in_tick_now         one update call
// out       output     out_valid, out_stall, out_duty_out,     one duty result
//                      out_mode_after
// cfg       input      psel, penable, pwrite, paddr, pwdata,   one register access
//                      prdata, pready
//
// Off, on and due fade updates pass through the idle, load and emit states; a fade update
// that is not yet due, or one in an unused mode, ends after load and gives no result.
// A sine update makes two passes through the shared divider, first for the phase index
// and then for the sine magnitude, before it reaches the emit state.
// Reset clears the control state; the state memory reads as zero until its
// first write, so there is no clearing pass.
// A finished result waits in the output register while out_stall is high and
// the next transaction is already accepted; its result waits in turn.
module led_brightness_mode_sequencer_core import ledbms_pkg::*; #(
  parameter int SINE_TABLE_SIZE = SINE_TABLE_SIZE_DEF,
  parameter int FADE_STEP       = FADE_STEP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_tick_now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_duty_out,
  output logic [2:0]  out_mode_after,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW    = $clog2(SINE_TABLE_SIZE + 1);
  localparam int W_W   = 2 * SW;
  localparam int NUM_W = W_W + MAG_K_W;
  localparam int DEN_W = W_W + 3;
  localparam int PH_W  = 16 + SW;
  localparam int DVD_W = (NUM_W > PH_W) ? NUM_W : PH_W;
  localparam int DVS_W = (DEN_W > 16) ? DEN_W : 16;

  localparam logic [SW-1:0]    S_C      = SW'(SINE_TABLE_SIZE);
  localparam logic [DEN_W-1:0] DEN_BASE = DEN_W'(5 * SINE_TABLE_SIZE * SINE_TABLE_SIZE);
  localparam logic [12:0]      FADE13   = 13'(FADE_STEP);

  cfg_bus_t   cfg;
  fsm_state_t state_r, state_nxt;
  logic [2:0] mode_r;

  state_rec_t rd_rec, wr_rec;
  logic       mem_rd, mem_wr;

  logic [31:0]    tick_r;
  logic [15:0]    step_r;
  logic [SW-1:0]  a_r;
  logic           neg_r;
  logic [W_W-1:0] w_r;
  logic [11:0]    res_duty_r;
  logic [2:0]     res_mode_r;
  logic           out_valid_r;
  logic [11:0]    out_duty_r;
  logic [2:0]     out_mode_r;

  logic             div_start, div_busy, div_done;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic [DIV_QW-1:0] div_quo;

  logic        accept, emit_load;
  logic [31:0] elapsed;
  logic [15:0] per;
  logic [16:0] step_inc;
  logic [15:0] step_next;
  logic [12:0] fin_sum;
  logic        ld_emit, ld_wr, ld_sine;
  logic [2:0]  ld_mode;
  logic [11:0] ld_duty;

  logic [SW:0]   a2;
  logic [10:0]   mag;
  logic [11:0]   sine_duty;

  ledbms_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ledbms_state_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd),
    .rd_data (rd_rec),
    .wr_en   (mem_wr),
    .wr_data (wr_rec)
  );

  ledbms_divider #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W),
    .QW    (DIV_QW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Update rules applied to the record read back from the state memory.
  always_comb begin
    elapsed   = tick_r - rd_rec.last_tick;
    per       = (cfg.sine_period == 16'd0) ? 16'd1 : cfg.sine_period;
    step_inc  = {1'b0, rd_rec.sine_step} + 17'd1;
    step_next = (step_inc >= {1'b0, per}) ? 16'd0 : step_inc[15:0];
    fin_sum   = {1'b0, rd_rec.duty_level} + FADE13;
    ld_emit   = 1'b0;
    ld_wr     = 1'b0;
    ld_sine   = 1'b0;
    ld_mode   = mode_r;
    ld_duty   = 12'd0;
    wr_rec    = rd_rec;
    case (mode_r)
      MODE_OFF: begin
        ld_emit = 1'b1;
      end
      MODE_ON: begin
        ld_emit           = 1'b1;
        ld_wr             = 1'b1;
        ld_duty           = cfg.on_duty;
        wr_rec.duty_level = cfg.on_duty;
      end
      MODE_FADE_IN: begin
        if (elapsed >= cfg.fade_interval) begin
          ld_emit          = 1'b1;
          ld_wr            = 1'b1;
          wr_rec.last_tick = tick_r;
          if (fin_sum >= {1'b0, DUTY_MAX}) begin
            ld_duty = DUTY_MAX;
            ld_mode = MODE_FADE_OUT;
          end else begin
            ld_duty = fin_sum[11:0];
          end
          wr_rec.duty_level = ld_duty;
        end
      end
      MODE_FADE_OUT: begin
        if (elapsed > cfg.fade_interval) begin
          ld_emit          = 1'b1;
          ld_wr            = 1'b1;
          wr_rec.last_tick = tick_r;
          if ({1'b0, rd_rec.duty_level} <= FADE13) begin
            ld_duty = 12'd0;
            ld_mode = MODE_FADE_IN;
          end else begin
            ld_duty = rd_rec.duty_level - FADE13[11:0];
          end
          wr_rec.duty_level = ld_duty;
        end
      end
      MODE_SINE: begin
        ld_wr            = 1'b1;
        ld_sine          = 1'b1;
        wr_rec.sine_step = step_next;
        wr_rec.last_tick = tick_r;
      end
      default: ;
    endcase
  end

  // Folding of the phase into a half wave and the final sine duty.
  always_comb begin
    a2        = {SW'(div_quo), 1'b0};
    mag       = (div_quo > DUTY_MID) ? DUTY_MID[10:0] : div_quo[10:0];
    sine_duty = neg_r ? (DUTY_MID - {1'b0, mag}) : (DUTY_MID + {1'b0, mag});
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (ld_sine) begin
          state_nxt = ST_PHASE_GO;
        end else if (ld_emit) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PHASE_GO:   state_nxt = ST_PHASE_WAIT;
      ST_PHASE_WAIT: begin
        if (div_done) begin
          state_nxt = ST_WMUL;
        end
      end
      ST_WMUL:       state_nxt = ST_MAG_GO;
      ST_MAG_GO:     state_nxt = ST_MAG_WAIT;
      ST_MAG_WAIT: begin
        if (div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    accept    = (state_r == ST_IDLE) && in_valid;
    mem_rd    = accept;
    mem_wr    = (state_r == ST_LOAD) && ld_wr;
    div_start = (state_r == ST_PHASE_GO) || (state_r == ST_MAG_GO);
    emit_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
    if (state_r == ST_PHASE_GO) begin
      div_dvd = DVD_W'(step_r) * DVD_W'(SINE_TABLE_SIZE);
      div_dvs = DVS_W'(per);
    end else begin
      div_dvd = DVD_W'(w_r) * DVD_W'(MAG_K);
      div_dvs = DVS_W'(DEN_BASE - (DEN_W'(w_r) << 2));
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_OFF;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg.mode_wr) begin
        mode_r <= cfg.mode_val;
      end else if (state_r == ST_LOAD) begin
        mode_r <= ld_mode;
      end
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      tick_r <= in_tick_now;
    end
    if (state_r == ST_LOAD) begin
      step_r     <= step_next;
      res_duty_r <= ld_duty;
      res_mode_r <= ld_mode;
    end
    if ((state_r == ST_PHASE_WAIT) && div_done) begin
      if (a2 >= {1'b0, S_C}) begin
        a_r   <= SW'(a2 - {1'b0, S_C});
        neg_r <= 1'b1;
      end else begin
        a_r   <= a2[SW-1:0];
        neg_r <= 1'b0;
      end
    end
    if (state_r == ST_WMUL) begin
      w_r <= W_W'(a_r) * W_W'(S_C - a_r);
    end
    if ((state_r == ST_MAG_WAIT) && div_done) begin
      res_duty_r <= sine_duty;
    end
    if (emit_load) begin
      out_duty_r <= res_duty_r;
      out_mode_r <= res_mode_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_duty_out   = out_duty_r;
  assign out_mode_after = out_mode_r;

`ifndef SYNTHESIS
  // The shared divider is never restarted while an operation runs.
  assert property (@(posedge clk) disable iff (!rst_n) div_start |-> !div_busy)
    else $error("divider started while busy");

  // The state record is written back only right after its read.
  assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr |-> $past(accept))
    else $error("state write without a preceding read");

  // The phase index stays inside the sine table.
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_PHASE_WAIT) && div_done) |->
    (32'(div_quo) < 32'(SINE_TABLE_SIZE)))
    else $error("sine phase out of range");

  // A result in off mode always carries zero duty.
  assert property (@(posedge clk) disable iff (!rst_n)
    (emit_load && (res_mode_r == MODE_OFF)) |-> (res_duty_r == 12'd0))
    else $error("nonzero duty in off mode");
`endif

endmodule

FILE: sv/ledbms_cfg_regs.sv
module ledbms_cfg_regs import ledbms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_bus_t    cfg
);

  logic [2:0]  mode_select_r;
  logic [11:0] on_duty_r;
  logic [31:0] fade_interval_r;
  logic [15:0] sine_period_r;
  logic        wr_en;
  reg_idx_t    reg_idx;

  // The access phase completes without wait states.
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_select_r   <= 3'd0;
      on_duty_r       <= 12'd0;
      fade_interval_r <= 32'd0;
      sine_period_r   <= 16'd100;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MODE_SELECT:   mode_select_r   <= pwdata[2:0];
        REG_ON_DUTY:       on_duty_r       <= pwdata[11:0];
        REG_FADE_INTERVAL: fade_interval_r <= pwdata;
        REG_SINE_PERIOD:   sine_period_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    case (reg_idx)
      REG_MODE_SELECT:   prdata = {29'd0, mode_select_r};
      REG_ON_DUTY:       prdata = {20'd0, on_duty_r};
      REG_FADE_INTERVAL: prdata = fade_interval_r;
      REG_SINE_PERIOD:   prdata = {16'd0, sine_period_r};
      default:           prdata = 32'd0;
    endcase
  end

  // A mode write also loads the running mode of the sequencer.
  always_comb begin
    cfg.mode_wr       = wr_en && (reg_idx == REG_MODE_SELECT);
    cfg.mode_val      = pwdata[2:0];
    cfg.on_duty       = on_duty_r;
    cfg.fade_interval = fade_interval_r;
    cfg.sine_period   = sine_period_r;
  end

endmodule

FILE: sv/ledbms_state_mem.sv
module ledbms_state_mem import ledbms_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       rd_en,
  output state_rec_t rd_data,
  input  logic       wr_en,
  input  state_rec_t wr_data
);

  state_rec_t state_mem_r [1];
  state_rec_t rd_data_r;
  logic       vld_r;

  // The entry reads as all zeros until the first write after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (wr_en) begin
      vld_r <= 1'b1;
    end
  end

  // Synchronous write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      state_mem_r[0] <= wr_data;
    end
  end

  // Synchronous read port; the read data is registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= vld_r ? state_mem_r[0] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/ledbms_divider.sv
module ledbms_divider #(
  parameter int DVD_W = 41,
  parameter int DVS_W = 29,
  parameter int QW    = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [QW-1:0]    quotient
);

  // Restoring division, one quotient bit per cycle, most significant first.
  // The caller guarantees that the quotient fits in QW bits.
  localparam int CW    = (DVD_W > DVS_W + QW - 1) ? DVD_W : DVS_W + QW - 1;
  localparam int CNT_W = $clog2(QW + 1);

  logic [CW-1:0]    rem_r;
  logic [CW-1:0]    dvs_r;
  logic [QW-1:0]    quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic             ge;

  assign busy     = (cnt_r != '0);
  assign done     = done_r;
  assign quotient = quo_r;
  assign ge       = (rem_r >= dvs_r);

  // Iteration count and completion strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy && (cnt_r == CNT_W'(1));
      if (start) begin
        cnt_r <= CNT_W'(QW);
      end else if (busy) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // Partial remainder, shifted divisor and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= CW'(dividend);
      dvs_r <= CW'(divisor) << (QW - 1);
      quo_r <= '0;
    end else if (busy) begin
      if (ge) begin
        rem_r <= rem_r - dvs_r;
      end
      quo_r <= {quo_r[QW-2:0], ge};
      dvs_r <= dvs_r >> 1;
    end
  end

endmodule

FILE: test/led_brightness_mode_sequencer_checker.sv
`timescale 1ns / 100ps

module led_brightness_mode_sequencer_checker import ledbms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_tick_now,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [11:0] out_duty_out,
  input  logic [2:0]  out_mode_after,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [11:0] duty;
    logic [2:0]  mode;
  } duty_result_t;

  // Duty results predicted but not yet seen on the output channel.
  duty_result_t pending_duty_q[$];

  // Shadow copies of the configuration registers.
  logic [11:0] on_level;
  logic [31:0] fade_gap;
  logic [15:0] period_reg;

  // Shadow copy of the sequencer state.
  logic [2:0]  cur_mode;
  logic [11:0] level;
  logic [31:0] last_tick;
  logic [15:0] sine_pos;

  bit           fired;
  duty_result_t predicted;
  duty_result_t oldest;

  // Duty of one sine step: rational approximation of the sine over the phase index.
  function automatic logic [11:0] sine_duty_of(input logic [15:0] pos,
                                               input logic [16:0] per);
    longint unsigned tsz;
    longint unsigned mid;
    longint unsigned ph;
    longint unsigned a;
    longint unsigned w;
    longint unsigned mag;
    logic            neg;
    tsz = SINE_TABLE_SIZE_DEF;
    mid = DUTY_MID;
    ph  = (longint'(pos) * tsz) / longint'(per);
    a   = 2 * ph;
    neg = 1'b0;
    if (a >= tsz) begin
      a   = a - tsz;
      neg = 1'b1;
    end
    if (a > tsz) begin
      a = tsz;
    end
    w   = a * (tsz - a);
    mag = (mid * 16 * w) / (5 * tsz * tsz - 4 * w);
    if (mag > mid) begin
      mag = mid;
    end
    return neg ? 12'(mid - mag) : 12'(mid + mag);
  endfunction

  // Advances the shadow state by one update call and tells whether a duty comes out.
  task automatic step_sequencer(input logic [31:0] now, output bit emits,
                                output duty_result_t res);
    logic [31:0] elapsed;
    logic [12:0] up;
    int          dn;
    logic [16:0] per;
    logic [16:0] nxt;
    elapsed  = now - last_tick;
    emits    = 1'b1;
    res.duty = '0;
    case (cur_mode)
      MODE_OFF: begin
        res.duty = '0;
      end
      MODE_ON: begin
        level    = on_level;
        res.duty = level;
      end
      MODE_FADE_IN: begin
        if (elapsed < fade_gap) begin
          emits = 1'b0;
        end else begin
          up = {1'b0, level} + 13'(FADE_STEP_DEF);
          if (up >= {1'b0, DUTY_MAX}) begin
            level    = DUTY_MAX;
            cur_mode = MODE_FADE_OUT;
          end else begin
            level = up[11:0];
          end
          last_tick = now;
          res.duty  = level;
        end
      end
      MODE_FADE_OUT: begin
        if (elapsed <= fade_gap) begin
          emits = 1'b0;
        end else begin
          dn = int'(level) - FADE_STEP_DEF;
          if (dn <= 0) begin
            level    = '0;
            cur_mode = MODE_FADE_IN;
          end else begin
            level = 12'(dn);
          end
          last_tick = now;
          res.duty  = level;
        end
      end
      MODE_SINE: begin
        // A zero period behaves as a period of one.
        per = (period_reg == '0) ? 17'd1 : {1'b0, period_reg};
        nxt = {1'b0, sine_pos} + 17'd1;
        if (nxt >= per) begin
          nxt = '0;
        end
        sine_pos  = nxt[15:0];
        last_tick = now;
        res.duty  = sine_duty_of(sine_pos, per);
      end
      default: begin
        // Unused mode codes produce nothing and change nothing.
        emits = 1'b0;
      end
    endcase
    res.mode = cur_mode;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mismatches = 0;
      on_level   = '0;
      fade_gap   = '0;
      period_reg = 16'd100;
      cur_mode   = MODE_OFF;
      level      = '0;
      last_tick  = '0;
      sine_pos   = '0;
      pending_duty_q.delete();
    end else begin
      // Register writes; a mode write loads the running mode at once.
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_MODE_SELECT:   cur_mode   = pwdata[2:0];
          REG_ON_DUTY:       on_level   = pwdata[11:0];
          REG_FADE_INTERVAL: fade_gap   = pwdata;
          REG_SINE_PERIOD:   period_reg = pwdata[15:0];
          default: ;
        endcase
      end

      // Compare each result transaction with the oldest prediction.
      if (out_valid && !out_stall) begin
        if (pending_duty_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected duty result: duty %0d mode %0d",
                     $realtime, out_duty_out, out_mode_after);
          end
        end else begin
          oldest = pending_duty_q.pop_front();
          if (out_duty_out !== oldest.duty || out_mode_after !== oldest.mode) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: duty result mismatch: expected duty %0d mode %0d,",
                       $realtime, oldest.duty, oldest.mode,
                       " got duty %0d mode %0d", out_duty_out, out_mode_after);
            end
          end
        end
      end

      // Predict the outcome of each accepted update transaction.
      if (in_valid && !in_stall) begin
        step_sequencer(in_tick_now, fired, predicted);
        if (fired) begin
          pending_duty_q.push_back(predicted);
        end
      end
    end
    outstanding = pending_duty_q.size();
  end

endmodule

FILE: test/tb_led_brightness_mode_sequencer_core.sv
`timescale 1ns / 100ps

module tb_led_brightness_mode_sequencer_core;
  import ledbms_pkg::*;

  localparam int          RANDOM_ITEMS   = 1150;
  localparam int          QUIET_LIMIT    = 3000;
  localparam int          DRAIN_CYCLES   = 40;
  localparam logic [2:0]  MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0]  MODE_UNUSED_HI = 3'd7;

  typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_BLOCKS} stall_style_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic [31:0] in_tick_now = '0;
  logic        out_stall   = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [3:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;

  logic        in_stall;
  logic        out_valid;
  logic [11:0] out_duty_out;
  logic [2:0]  out_mode_after;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int outstanding;

  int           quiet_cycles = 0;
  int           burst_left   = 0;
  int           issued       = 0;
  int           r;
  int           n;
  logic [2:0]   live_mode    = MODE_OFF;
  logic [31:0]  tick_ctr     = '0;
  stall_style_t stall_style  = STALL_NONE;
  int           stall_seg    = 0;
  int           stall_run    = 0;
  logic         stall_hold   = 1'b0;

  always #6 clk = ~clk;

  led_brightness_mode_sequencer_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_tick_now    (in_tick_now),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_duty_out   (out_duty_out),
    .out_mode_after (out_mode_after),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  led_brightness_mode_sequencer_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_tick_now    (in_tick_now),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_duty_out   (out_duty_out),
    .out_mode_after (out_mode_after),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  // The result side stalls in segments of varying style, some with no stall at all.
  always @(negedge clk) begin
    if (stall_seg == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      stall_seg   = $urandom_range(16, 160);
    end
    stall_seg--;
    case (stall_style)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_COIN:  out_stall <= ($urandom_range(0, 1) == 1);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_run == 0) begin
          stall_hold = !stall_hold;
          stall_run  = $urandom_range(1, 20);
        end
        stall_run--;
        out_stall <= stall_hold;
      end
    endcase
  end

  // Watchdog: end the run when no transaction completes for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one update transaction. Called at a falling edge; returns at the falling edge
  // after acceptance with valid still high, so the caller either sends again or lowers it.
  task automatic push_tick(input logic [31:0] t);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_tick_now <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // One register write: setup cycle, then access cycle.
  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    if (idx == REG_MODE_SELECT) begin
      live_mode = value[2:0];
    end
  endtask

  task automatic cfg_idle();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stop sending and let the block go idle before touching the registers.
  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Off mode straight out of reset, at both ends of the tick range.
    push_tick(32'h0000_0000);
    push_tick(32'hFFFF_FFFF);

    // On mode at both duty extremes.
    settle();
    cfg_write(REG_ON_DUTY, 32'd4095);
    cfg_write(REG_MODE_SELECT, 32'(MODE_ON));
    cfg_idle();
    push_tick(32'd7);
    settle();
    cfg_write(REG_ON_DUTY, 32'd0);
    cfg_idle();
    push_tick(32'd8);

    // Fade in that clamps at full scale and turns to fade out.
    settle();
    cfg_write(REG_ON_DUTY, 32'd4090);
    cfg_idle();
    push_tick(32'd9);
    settle();
    cfg_write(REG_FADE_INTERVAL, 32'd0);
    cfg_write(REG_MODE_SELECT, 32'(MODE_FADE_IN));
    cfg_idle();
    push_tick(32'd9);
    push_tick(32'd9);
    push_tick(32'd10);

    // Fade out that clamps at zero and turns to fade in.
    settle();
    cfg_write(REG_ON_DUTY, 32'd30);
    cfg_write(REG_MODE_SELECT, 32'(MODE_ON));
    cfg_idle();
    push_tick(32'd11);
    settle();
    cfg_write(REG_MODE_SELECT, 32'(MODE_FADE_OUT));
    cfg_idle();
    push_tick(32'd12);
    push_tick(32'd12);

    // Largest interval: fade in fires only at full elapsed span, fade out never.
    settle();
    cfg_write(REG_FADE_INTERVAL, 32'hFFFF_FFFF);
    cfg_idle();
    push_tick(32'd13);
    push_tick(32'd11);
    settle();
    cfg_write(REG_MODE_SELECT, 32'(MODE_FADE_OUT));
    cfg_idle();
    push_tick(32'd10);

    // Elapsed time across the wrap of the tick counter.
    settle();
    cfg_write(REG_FADE_INTERVAL, 32'd5);
    cfg_write(REG_MODE_SELECT, 32'(MODE_FADE_IN));
    cfg_idle();
    push_tick(32'hFFFF_FFFE);
    push_tick(32'd3);
    push_tick(32'd7);

    // Sine at the reset period, then a lowered period below the current step.
    settle();
    cfg_write(REG_MODE_SELECT, 32'(MODE_SINE));
    cfg_idle();
    push_tick(32'd20);
    push_tick(32'd21);
    push_tick(32'd22);
    settle();
    cfg_write(REG_SINE_PERIOD, 32'd2);
    cfg_idle();
    push_tick(32'd23);

    // Sine with zero, unit and largest periods.
    settle();
    cfg_write(REG_SINE_PERIOD, 32'd0);
    cfg_idle();
    push_tick(32'd24);
    push_tick(32'd25);
    settle();
    cfg_write(REG_SINE_PERIOD, 32'd1);
    cfg_idle();
    push_tick(32'd26);
    settle();
    cfg_write(REG_SINE_PERIOD, 32'd65535);
    cfg_idle();
    push_tick(32'd27);
    push_tick(32'd28);

    // Unused mode codes are ignored.
    settle();
    cfg_write(REG_MODE_SELECT, 32'(MODE_UNUSED_LO));
    cfg_idle();
    push_tick(32'd29);
    settle();
    cfg_write(REG_MODE_SELECT, 32'(MODE_UNUSED_HI));
    cfg_idle();
    push_tick(32'd30);
    settle();
    cfg_write(REG_MODE_SELECT, 32'(MODE_UNUSED_LO + 3'd1));
    cfg_idle();
    push_tick(32'd31);

    // Random phases: a few register writes, then a run of update calls.
    while (issued < RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(0, 9) < 6) begin
        r = $urandom_range(0, 99);
        if (r < 15) cfg_write(REG_ON_DUTY, 32'd0);
        else if (r < 30) cfg_write(REG_ON_DUTY, 32'd4095);
        else cfg_write(REG_ON_DUTY, 32'($urandom_range(0, 4095)));
      end
      if ($urandom_range(0, 9) < 6) begin
        r = $urandom_range(0, 99);
        if (r < 60) cfg_write(REG_FADE_INTERVAL, 32'($urandom_range(0, 12)));
        else if (r < 75) cfg_write(REG_FADE_INTERVAL, 32'd0);
        else if (r < 85) cfg_write(REG_FADE_INTERVAL, $urandom);
        else if (r < 90) cfg_write(REG_FADE_INTERVAL, 32'hFFFF_FFFF);
        else cfg_write(REG_FADE_INTERVAL, 32'($urandom_range(13, 100)));
      end
      if ($urandom_range(0, 9) < 6) begin
        r = $urandom_range(0, 99);
        if (r < 50) cfg_write(REG_SINE_PERIOD, 32'($urandom_range(1, 64)));
        else if (r < 70) cfg_write(REG_SINE_PERIOD, 32'($urandom_range(65, 2000)));
        else if (r < 80) cfg_write(REG_SINE_PERIOD, 32'd0);
        else if (r < 85) cfg_write(REG_SINE_PERIOD, 32'd1);
        else if (r < 90) cfg_write(REG_SINE_PERIOD, 32'd65535);
        else cfg_write(REG_SINE_PERIOD, 32'($urandom_range(0, 65535)));
      end
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 99) < 94) begin
          cfg_write(REG_MODE_SELECT, 32'($urandom_range(MODE_OFF, MODE_SINE)));
        end else begin
          cfg_write(REG_MODE_SELECT, 32'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)));
        end
      end
      cfg_idle();

      n = (live_mode > MODE_SINE) ? $urandom_range(1, 4) : $urandom_range(10, 60);
      repeat (n) begin
        // Mostly small tick advances, with jumps and backward steps mixed in.
        r = $urandom_range(0, 99);
        if (r < 80) tick_ctr = tick_ctr + 32'($urandom_range(0, 16));
        else if (r < 92) tick_ctr = $urandom;
        else tick_ctr = tick_ctr - 32'($urandom_range(1, 8));
        push_tick(tick_ctr);
        if (live_mode <= MODE_SINE) begin
          issued++;
        end
      end
    end

    // Drain the remaining results, then give the verdict.
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
